/* hw/rtl/assert_macros.svh */
// Assertion shorthands shared by the date conversion RTL.
// Every module that uses them has ports named clock and reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high
`define ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, switched off while reset is high
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/dcdate_pkg.sv */
package dcdate_pkg;

   // Field widths
   localparam int unsigned DayW    = 22;
   localparam int unsigned MsW     = 27;
   localparam int unsigned YearW   = 14;
   localparam int unsigned MonthW  = 4;
   localparam int unsigned MdayW   = 5;
   localparam int unsigned DoyW    = 9;
   localparam int unsigned WdayW   = 3;
   localparam int unsigned HourW   = 5;
   localparam int unsigned MinuteW = 6;
   localparam int unsigned SecondW = 6;

   // Input limits
   localparam logic [DayW-1:0] DayFirst = 22'd1;
   localparam logic [DayW-1:0] DayLast  = 22'd3652059;
   localparam logic [MsW-1:0]  MsLast   = 27'd86399999;

   // Time-of-day units
   localparam int unsigned HoursPerDay      = 24;
   localparam int unsigned MinutesPerHour   = 60;
   localparam int unsigned SecondsPerMinute = 60;
   localparam logic [MsW-1:0] MsPerHour   = 27'd3600000;
   localparam logic [MsW-1:0] MsPerMinute = 27'd60000;
   localparam logic [MsW-1:0] MsPerSecond = 27'd1000;

   // Remainder widths after each split
   localparam int unsigned RemHourW   = 22;
   localparam int unsigned RemMinuteW = 16;

   // Reciprocals for exact quotients: shift = input bits + ceil(log2(divisor))
   localparam int unsigned HourShift   = 49;
   localparam int unsigned HourRecipW  = 28;
   localparam logic [HourRecipW-1:0] HourRecip = HourRecipW'(
      ((64'd1 << HourShift) + 64'(MsPerHour) - 64'd1) / 64'(MsPerHour));

   localparam int unsigned MinuteShift  = 38;
   localparam int unsigned MinuteRecipW = 23;
   localparam logic [MinuteRecipW-1:0] MinuteRecip = MinuteRecipW'(
      ((64'd1 << MinuteShift) + 64'(MsPerMinute) - 64'd1) / 64'(MsPerMinute));

   localparam int unsigned SecondShift  = 26;
   localparam int unsigned SecondRecipW = 17;
   localparam logic [SecondRecipW-1:0] SecondRecip = SecondRecipW'(
      ((64'd1 << SecondShift) + 64'(MsPerSecond) - 64'd1) / 64'(MsPerSecond));

   // Time of day handed from the splitter to the top level
   typedef struct packed {
      logic [HourW-1:0]   hour;
      logic [MinuteW-1:0] minute;
      logic [SecondW-1:0] second;
   } tod_type;

endpackage

/* hw/rtl/day_count_to_calendar_date_unit.sv */
// Day count to calendar date converter.
// Request: raise start with req_day_count (day 1 = 1 Jan of year 1) and
// req_msec_of_day; the transaction is taken on a clock edge where start is
// high and busy is low. A day count of zero counts as day 1, counts beyond
// 31 Dec 9999 and milliseconds beyond the day saturate.
// Response: rsp_valid is high for one cycle with year minus 1900, month
// (0 = Jan), day of month, day of year (0 = 1 Jan), weekday (0 = Sunday)
// and hour, minute, second. The receiver cannot stall; results are shown
// once and must be taken in that cycle.
// Throughput: one transaction per cycle, through the seven-stage
// pipeline (input clamp, year estimate by reciprocal multiply, century
// quotients, year-end sums, year selection, month search and
// day-of-month subtract, with the time split running alongside).
// Reset: synchronous; clears all stage valid bits, so nothing in flight is
// reported. busy is high during reset and in the cycle after it, and
// low from then on.
`include "assert_macros.svh"

module day_count_to_calendar_date_unit
   import dcdate_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic [DayW-1:0]         req_day_count,
   input  logic [MsW-1:0]          req_msec_of_day,
   output logic                    rsp_valid,
   output logic signed [YearW-1:0] rsp_year_from_1900,
   output logic [MonthW-1:0]       rsp_month_index,
   output logic [MdayW-1:0]        rsp_day_of_month,
   output logic [DoyW-1:0]         rsp_day_of_year,
   output logic [WdayW-1:0]        rsp_weekday,
   output logic [HourW-1:0]        rsp_hour,
   output logic [MinuteW-1:0]      rsp_minute,
   output logic [SecondW-1:0]      rsp_second
);

   localparam int unsigned PipeDepth = 7;

   // Year estimate days*400/146097, rounded down (never above the true year)
   localparam int unsigned YearShift  = 32;
   localparam int unsigned YearRecipW = 24;
   localparam logic [YearRecipW-1:0] YearRecip = YearRecipW'(
      ((64'd1 << YearShift) * 64'd400) / 64'd146097);
   localparam int unsigned YearProdW = DayW + YearRecipW;

   // Exact day count / 7
   localparam int unsigned DaysPerWeek = 7;
   localparam int unsigned WeekShift   = 25;
   localparam int unsigned WeekRecipW  = 23;
   localparam logic [WeekRecipW-1:0] WeekRecip = WeekRecipW'(
      ((64'd1 << WeekShift) + 64'(DaysPerWeek) - 64'd1) / 64'(DaysPerWeek));
   localparam int unsigned WeekProdW = DayW + WeekRecipW;
   localparam int unsigned WeekQuotW = 20;

   // Exact year / 100
   localparam int unsigned YearsPerCentury = 100;
   localparam int unsigned CentShift  = 21;
   localparam int unsigned CentRecipW = 15;
   localparam logic [CentRecipW-1:0] CentRecip = CentRecipW'(
      ((64'd1 << CentShift) + 64'(YearsPerCentury) - 64'd1) / 64'(YearsPerCentury));
   localparam int unsigned CentProdW = YearW + CentRecipW;
   localparam int unsigned CentQuotW = 8;

   // Days in years 1..y
   localparam int unsigned YearDaysW   = 23;
   localparam int unsigned DaysPerYear = 365;
   localparam int unsigned YearBase    = 1900;

   // Year candidates: estimate-1 up to estimate+2
   localparam int unsigned NumCand = 4;
   localparam int unsigned NumSums = 3;

   localparam int unsigned MonthsPerYear = 12;
   localparam int unsigned MarchIndex    = 2;
   localparam logic [DoyW-1:0] MonthStart [MonthsPerYear] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
   };

   function automatic logic [YearW-1:0] year_cand(input logic [YearW-1:0] est,
                                                  input int unsigned idx);
      return est + YearW'(idx) - YearW'(1);
   endfunction

   function automatic logic [YearDaysW-1:0] year_end_days(input logic [YearW-1:0] year,
                                                          input logic [CentQuotW-1:0] cent);
      return YearDaysW'(year) * YearDaysW'(DaysPerYear) + YearDaysW'(year >> 2)
           - YearDaysW'(cent) + YearDaysW'(cent >> 2);
   endfunction

   // Days before the first of a 0-based month
   function automatic logic [DoyW-1:0] month_first(input logic [MonthW-1:0] month,
                                                   input logic leap);
      logic [DoyW-1:0] first;
      first = MonthStart[month];
      if (leap && month >= MonthW'(MarchIndex)) begin
         first = first + DoyW'(1);
      end
      return first;
   endfunction

   logic busy_ff;
   logic accept;
   logic valid_s1_ff, valid_s2_ff, valid_s3_ff, valid_s4_ff;
   logic valid_s5_ff, valid_s6_ff, rsp_valid_ff;

   // Stage 1: clamped inputs
   logic [DayW-1:0] days_s1_ff, days_s1_in;
   logic [MsW-1:0]  ms_s1_ff, ms_s1_in;

   // Stage 2: year estimate, week quotient
   logic [YearProdW-1:0] year_prod;
   logic [WeekProdW-1:0] week_prod;
   logic [DayW-1:0]      days_s2_ff;
   logic [YearW-1:0]     est_s2_ff, est_s2_in;
   logic [WeekQuotW-1:0] week_quot_s2_ff, week_quot_s2_in;

   // Stage 3: century quotients of the candidates, weekday
   logic [CentProdW-1:0] cent_prod [NumCand];
   logic [DayW-1:0]      week_diff;
   logic [DayW-1:0]      days_s3_ff;
   logic [YearW-1:0]     est_s3_ff;
   logic [CentQuotW-1:0] cent_s3_ff [NumCand];
   logic [CentQuotW-1:0] cent_s3_in [NumCand];
   logic [WdayW-1:0]     wday_s3_ff, wday_s3_in;

   // Stage 4: year-end day sums, century-year flags
   logic [DayW-1:0]      days_s4_ff;
   logic [YearW-1:0]     est_s4_ff;
   logic [CentQuotW-1:0] cent_s4_ff [NumCand];
   logic                 century_s4_ff [NumCand];
   logic                 century_s4_in [NumCand];
   logic [YearDaysW-1:0] sum_s4_ff [NumSums];
   logic [YearDaysW-1:0] sum_s4_in [NumSums];
   logic [WdayW-1:0]     wday_s4_ff;

   // Stage 5: selected year, day of year, leap flag
   logic [YearDaysW-1:0] base_days;
   logic [YearDaysW-1:0] doy_diff;
   logic [CentQuotW-1:0] sel_cent;
   logic                 sel_century;
   logic [YearW-1:0]     year_s5_ff, year_s5_in;
   logic [DoyW-1:0]      doy_s5_ff, doy_s5_in;
   logic                 leap_s5_ff, leap_s5_in;
   logic [WdayW-1:0]     wday_s5_ff;

   // Stage 6: month
   logic [YearW-1:0]  year_s6_ff;
   logic [DoyW-1:0]   doy_s6_ff;
   logic              leap_s6_ff;
   logic [MonthW-1:0] month_s6_ff, month_s6_in;
   logic [WdayW-1:0]  wday_s6_ff;

   // Stage 7: response registers
   logic [YearW-1:0]   year_out_ff, year_out_in;
   logic [MonthW-1:0]  month_out_ff;
   logic [DoyW-1:0]    mday_diff;
   logic [MdayW-1:0]   mday_out_ff, mday_out_in;
   logic [DoyW-1:0]    doy_out_ff, doy_out_in;
   logic [WdayW-1:0]   wday_out_ff;
   tod_type            tod_out_ff;

   logic    tod_valid;
   tod_type tod;

   assign accept = start && !busy_ff;

   // Stage 1: saturate the inputs
   always_comb begin
      priority if (req_day_count == '0) begin
         days_s1_in = DayFirst;
      end else if (req_day_count > DayLast) begin
         days_s1_in = DayLast;
      end else begin
         days_s1_in = req_day_count;
      end
      ms_s1_in = (req_msec_of_day > MsLast) ? MsLast : req_msec_of_day;
   end

   // Stage 2: reciprocal multiplies
   assign year_prod       = YearProdW'(days_s1_ff) * YearProdW'(YearRecip);
   assign est_s2_in       = year_prod[YearShift +: YearW];
   assign week_prod       = WeekProdW'(days_s1_ff) * WeekProdW'(WeekRecip);
   assign week_quot_s2_in = week_prod[WeekShift +: WeekQuotW];

   // Stage 3: year/100 for each candidate, day count mod 7
   always_comb begin
      for (int i = 0; i < NumCand; i++) begin
         cent_prod[i]  = CentProdW'(year_cand(est_s2_ff, i)) * CentProdW'(CentRecip);
         cent_s3_in[i] = cent_prod[i][CentShift +: CentQuotW];
      end
   end
   assign week_diff  = days_s2_ff - DayW'(week_quot_s2_ff) * DayW'(DaysPerWeek);
   assign wday_s3_in = week_diff[WdayW-1:0];

   // Stage 4: days up to the end of the first three candidate years, century flags of all four
   always_comb begin
      for (int i = 0; i < NumSums; i++) begin
         sum_s4_in[i] = year_end_days(year_cand(est_s3_ff, i), cent_s3_ff[i]);
      end
      for (int i = 0; i < NumCand; i++) begin
         century_s4_in[i] = (year_cand(est_s3_ff, i)
                             == YearW'(cent_s3_ff[i]) * YearW'(YearsPerCentury));
      end
   end

   // Stage 5: first candidate from the estimate upward whose year end reaches the day
   always_comb begin
      priority if (sum_s4_ff[1] >= YearDaysW'(days_s4_ff)) begin
         year_s5_in  = year_cand(est_s4_ff, 1);
         base_days   = sum_s4_ff[0];
         sel_cent    = cent_s4_ff[1];
         sel_century = century_s4_ff[1];
      end else if (sum_s4_ff[2] >= YearDaysW'(days_s4_ff)) begin
         year_s5_in  = year_cand(est_s4_ff, 2);
         base_days   = sum_s4_ff[1];
         sel_cent    = cent_s4_ff[2];
         sel_century = century_s4_ff[2];
      end else begin
         year_s5_in  = year_cand(est_s4_ff, 3);
         base_days   = sum_s4_ff[2];
         sel_cent    = cent_s4_ff[3];
         sel_century = century_s4_ff[3];
      end
      doy_diff   = YearDaysW'(days_s4_ff) - base_days;
      doy_s5_in  = doy_diff[DoyW-1:0];
      leap_s5_in = (year_s5_in[1:0] == 2'b00) && (!sel_century || sel_cent[1:0] == 2'b00);
   end

   // Stage 6: month = number of month starts the day lies past
   always_comb begin
      logic [MonthW-1:0] month_count;
      month_count = '0;
      for (int k = 1; k < MonthsPerYear; k++) begin
         if (doy_s5_ff > month_first(MonthW'(k), leap_s5_ff)) begin
            month_count = month_count + MonthW'(1);
         end
      end
      month_s6_in = month_count;
   end

   // Stage 7: day of month and output formatting
   assign mday_diff   = doy_s6_ff - month_first(month_s6_ff, leap_s6_ff);
   assign mday_out_in = mday_diff[MdayW-1:0];
   assign doy_out_in  = doy_s6_ff - DoyW'(1);
   assign year_out_in = year_s6_ff - YearW'(YearBase);

   // Time of day split runs alongside stages 2 to 6
   dcdate_tod_split u_tod_split (
      .clock     (clock),
      .reset     (reset),
      .ms_valid  (valid_s1_ff),
      .ms_value  (ms_s1_ff),
      .tod_valid (tod_valid),
      .tod       (tod)
   );

   // Control: busy and the valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         valid_s1_ff  <= 1'b0;
         valid_s2_ff  <= 1'b0;
         valid_s3_ff  <= 1'b0;
         valid_s4_ff  <= 1'b0;
         valid_s5_ff  <= 1'b0;
         valid_s6_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= 1'b0;
         valid_s1_ff  <= accept;
         valid_s2_ff  <= valid_s1_ff;
         valid_s3_ff  <= valid_s2_ff;
         valid_s4_ff  <= valid_s3_ff;
         valid_s5_ff  <= valid_s4_ff;
         valid_s6_ff  <= valid_s5_ff;
         rsp_valid_ff <= valid_s6_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      days_s1_ff      <= days_s1_in;
      ms_s1_ff        <= ms_s1_in;
      days_s2_ff      <= days_s1_ff;
      est_s2_ff       <= est_s2_in;
      week_quot_s2_ff <= week_quot_s2_in;
      days_s3_ff      <= days_s2_ff;
      est_s3_ff       <= est_s2_ff;
      wday_s3_ff      <= wday_s3_in;
      days_s4_ff      <= days_s3_ff;
      est_s4_ff       <= est_s3_ff;
      wday_s4_ff      <= wday_s3_ff;
      for (int i = 0; i < NumCand; i++) begin
         cent_s3_ff[i]    <= cent_s3_in[i];
         cent_s4_ff[i]    <= cent_s3_ff[i];
         century_s4_ff[i] <= century_s4_in[i];
      end
      for (int i = 0; i < NumSums; i++) begin
         sum_s4_ff[i] <= sum_s4_in[i];
      end
      year_s5_ff   <= year_s5_in;
      doy_s5_ff    <= doy_s5_in;
      leap_s5_ff   <= leap_s5_in;
      wday_s5_ff   <= wday_s4_ff;
      year_s6_ff   <= year_s5_ff;
      doy_s6_ff    <= doy_s5_ff;
      leap_s6_ff   <= leap_s5_ff;
      month_s6_ff  <= month_s6_in;
      wday_s6_ff   <= wday_s5_ff;
      year_out_ff  <= year_out_in;
      month_out_ff <= month_s6_ff;
      mday_out_ff  <= mday_out_in;
      doy_out_ff   <= doy_out_in;
      wday_out_ff  <= wday_s6_ff;
      tod_out_ff   <= tod;
   end

   assign busy               = busy_ff;
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_year_from_1900 = year_out_ff;
   assign rsp_month_index    = month_out_ff;
   assign rsp_day_of_month   = mday_out_ff;
   assign rsp_day_of_year    = doy_out_ff;
   assign rsp_weekday        = wday_out_ff;
   assign rsp_hour           = tod_out_ff.hour;
   assign rsp_minute         = tod_out_ff.minute;
   assign rsp_second         = tod_out_ff.second;

   `ASSERT_IMPLIES(a_latency, start && !busy, ##PipeDepth rsp_valid,
                   "accepted transaction not answered")
   `ASSERT_IMPLIES(a_no_spurious, rsp_valid, $past(start && !busy, PipeDepth),
                   "response without a request")
   `ASSERT_IMPLIES(a_doy_range, valid_s5_ff,
                   doy_s5_ff != '0 && doy_s5_ff <= DoyW'(DaysPerYear + 1),
                   "year selection missed")
   `ASSERT_IMPLIES(a_tod_aligned, 1'b1, tod_valid == valid_s6_ff,
                   "time of day out of step with the date stages")
   `ASSERT_IMPLIES(a_date_range, rsp_valid,
                   rsp_month_index < MonthW'(MonthsPerYear) && rsp_day_of_month != '0
                   && rsp_weekday < WdayW'(DaysPerWeek),
                   "date field out of range")

endmodule

/* hw/rtl/dcdate_tod_split.sv */
`include "assert_macros.svh"

module dcdate_tod_split
   import dcdate_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           ms_valid,
   input  logic [MsW-1:0] ms_value,
   output logic           tod_valid,
   output tod_type        tod
);

   localparam int unsigned HourProdW   = MsW + HourRecipW;
   localparam int unsigned MinuteProdW = RemHourW + MinuteRecipW;
   localparam int unsigned SecondProdW = RemMinuteW + SecondRecipW;

   // Valid bits, one per stage
   logic valid_s2_ff, valid_s3_ff, valid_s4_ff, valid_s5_ff, valid_s6_ff;

   logic [MsW-1:0]        ms_s2_ff;
   logic [HourW-1:0]      hour_s2_ff, hour_s2_in;
   logic [HourW-1:0]      hour_s3_ff, hour_s4_ff, hour_s5_ff;
   logic [RemHourW-1:0]   rem_hour_s3_ff, rem_hour_s3_in, rem_hour_s4_ff;
   logic [MinuteW-1:0]    minute_s4_ff, minute_s4_in, minute_s5_ff;
   logic [RemMinuteW-1:0] rem_minute_s5_ff, rem_minute_s5_in;
   tod_type               tod_s6_ff, tod_s6_in;

   logic [HourProdW-1:0]   hour_prod;
   logic [MsW-1:0]         hour_diff;
   logic [MinuteProdW-1:0] minute_prod;
   logic [RemHourW-1:0]    minute_diff;
   logic [SecondProdW-1:0] second_prod;

   // Stage 2: hour quotient
   assign hour_prod  = HourProdW'(ms_value) * HourProdW'(HourRecip);
   assign hour_s2_in = hour_prod[HourShift +: HourW];

   // Stage 3: milliseconds left within the hour
   assign hour_diff      = ms_s2_ff - MsW'(hour_s2_ff) * MsPerHour;
   assign rem_hour_s3_in = hour_diff[RemHourW-1:0];

   // Stage 4: minute quotient
   assign minute_prod  = MinuteProdW'(rem_hour_s3_ff) * MinuteProdW'(MinuteRecip);
   assign minute_s4_in = minute_prod[MinuteShift +: MinuteW];

   // Stage 5: milliseconds left within the minute
   assign minute_diff      = rem_hour_s4_ff
                           - RemHourW'(minute_s4_ff) * RemHourW'(MsPerMinute);
   assign rem_minute_s5_in = minute_diff[RemMinuteW-1:0];

   // Stage 6: second quotient, assemble result
   assign second_prod      = SecondProdW'(rem_minute_s5_ff) * SecondProdW'(SecondRecip);
   assign tod_s6_in.hour   = hour_s5_ff;
   assign tod_s6_in.minute = minute_s5_ff;
   assign tod_s6_in.second = second_prod[SecondShift +: SecondW];

   // Valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_s2_ff <= 1'b0;
         valid_s3_ff <= 1'b0;
         valid_s4_ff <= 1'b0;
         valid_s5_ff <= 1'b0;
         valid_s6_ff <= 1'b0;
      end else begin
         valid_s2_ff <= ms_valid;
         valid_s3_ff <= valid_s2_ff;
         valid_s4_ff <= valid_s3_ff;
         valid_s5_ff <= valid_s4_ff;
         valid_s6_ff <= valid_s5_ff;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      ms_s2_ff         <= ms_value;
      hour_s2_ff       <= hour_s2_in;
      hour_s3_ff       <= hour_s2_ff;
      rem_hour_s3_ff   <= rem_hour_s3_in;
      hour_s4_ff       <= hour_s3_ff;
      rem_hour_s4_ff   <= rem_hour_s3_ff;
      minute_s4_ff     <= minute_s4_in;
      hour_s5_ff       <= hour_s4_ff;
      minute_s5_ff     <= minute_s4_ff;
      rem_minute_s5_ff <= rem_minute_s5_in;
      tod_s6_ff        <= tod_s6_in;
   end

   assign tod_valid = valid_s6_ff;
   assign tod       = tod_s6_ff;

   `ASSERT_IMPLIES(a_rem_hour_range, valid_s3_ff, rem_hour_s3_ff < RemHourW'(MsPerHour), "hour quotient off by one")
   `ASSERT_NEXT(a_rem_minute_range, valid_s4_ff, rem_minute_s5_ff < RemMinuteW'(MsPerMinute), "minute quotient off by one")
   `ASSERT_IMPLIES(a_tod_range, tod_valid, tod.hour < HourW'(HoursPerDay) && tod.minute < MinuteW'(MinutesPerHour) && tod.second < SecondW'(SecondsPerMinute), "time of day out of range")

endmodule

/* tb/tb_day_count_to_calendar_date_unit.sv */
module tb_day_count_to_calendar_date_unit
   import dcdate_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned Latency     = 7;
   localparam int unsigned LimitCycles = 200000;
   localparam int unsigned RandomItems = 450;

   // Estimate constants: 400 Gregorian years hold 146097 days
   localparam int unsigned DaysPer400Years = 146097;
   localparam int unsigned YearsPerCycle   = 400;
   localparam int unsigned DaysPerYear     = 365;
   localparam int unsigned LastFeb28Day    = 59;
   localparam int unsigned MonthBias       = 3007;
   localparam int unsigned MonthStep       = 3057;
   localparam int unsigned DaysPerWeek     = 7;

   localparam int unsigned MonthFirstDay [12] =
      '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

   typedef struct packed {
      logic signed [YearW-1:0] year;
      logic [MonthW-1:0]       month;
      logic [MdayW-1:0]        mday;
      logic [DoyW-1:0]         yday;
      logic [WdayW-1:0]        wday;
      logic [HourW-1:0]        hour;
      logic [MinuteW-1:0]      minute;
      logic [SecondW-1:0]      second;
   } civil_date_type;

   typedef struct {
      logic [DayW-1:0] day;
      logic [MsW-1:0]  ms;
      bit              known;
      civil_date_type  want;
   } directed_row_type;

   // Monday 1 January of year 1, midnight
   localparam civil_date_type FirstDayMidnight =
      '{-14'sd1899, 4'd0, 5'd1, 9'd0, 3'd1, 5'd0, 6'd0, 6'd0};
   // Friday 31 December 9999, 23:59:59
   localparam civil_date_type LastDayLastSecond =
      '{14'sd8099, 4'd11, 5'd31, 9'd364, 3'd5, 5'd23, 6'd59, 6'd59};

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic [DayW-1:0]         req_day_count = '0;
   logic [MsW-1:0]          req_msec_of_day = '0;
   logic                    rsp_valid;
   logic signed [YearW-1:0] rsp_year_from_1900;
   logic [MonthW-1:0]       rsp_month_index;
   logic [MdayW-1:0]        rsp_day_of_month;
   logic [DoyW-1:0]         rsp_day_of_year;
   logic [WdayW-1:0]        rsp_weekday;
   logic [HourW-1:0]        rsp_hour;
   logic [MinuteW-1:0]      rsp_minute;
   logic [SecondW-1:0]      rsp_second;

   civil_date_type pending_dates [$];
   int unsigned mismatches     = 0;
   int unsigned dates_checked  = 0;
   int unsigned dates_sent     = 0;
   int unsigned cycle_count    = 0;
   int unsigned sender_idle_pct = 0;

   day_count_to_calendar_date_unit uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_day_count      (req_day_count),
      .req_msec_of_day    (req_msec_of_day),
      .rsp_valid          (rsp_valid),
      .rsp_year_from_1900 (rsp_year_from_1900),
      .rsp_month_index    (rsp_month_index),
      .rsp_day_of_month   (rsp_day_of_month),
      .rsp_day_of_year    (rsp_day_of_year),
      .rsp_weekday        (rsp_weekday),
      .rsp_hour           (rsp_hour),
      .rsp_minute         (rsp_minute),
      .rsp_second         (rsp_second)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Days in years 1..y inclusive
   function automatic int unsigned days_through_year(input int unsigned y);
      return y * DaysPerYear + y / 4 - y / 100 + y / 400;
   endfunction

   function automatic bit is_leap_year(input int unsigned y);
      return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
   endfunction

   // Expected calendar date and time of day for one request
   function automatic civil_date_type civil_date_of(input logic [DayW-1:0] day_in,
                                                    input logic [MsW-1:0] ms_in);
      int unsigned days, ms, yr, doy, stretched, mon, leap_shift;
      civil_date_type r;
      days = day_in;
      ms   = ms_in;
      if (days == 0) days = DayFirst;
      if (days > DayLast) days = DayLast;
      if (ms > MsLast) ms = MsLast;
      // estimate the year, then step up until it covers the day
      yr = int'((longint'(days) * YearsPerCycle) / DaysPer400Years);
      while (days_through_year(yr) < days) yr++;
      doy = days - days_through_year(yr - 1);
      // month from a table with February stretched to 30 days
      stretched = doy;
      if (stretched > LastFeb28Day) begin
         if (!is_leap_year(yr)) stretched += 2;
         else if (stretched > LastFeb28Day + 1) stretched += 1;
      end
      mon = (stretched * 100 + MonthBias) / MonthStep;
      leap_shift = (mon >= 3 && is_leap_year(yr)) ? 1 : 0;
      r.year   = YearW'(int'(yr) - 1900);
      r.month  = MonthW'(mon - 1);
      r.mday   = MdayW'(doy - MonthFirstDay[mon - 1] - leap_shift);
      r.yday   = DoyW'(doy - 1);
      r.wday   = WdayW'(days % DaysPerWeek);
      r.hour   = HourW'(ms / MsPerHour);
      r.minute = MinuteW'((ms % MsPerHour) / MsPerMinute);
      r.second = SecondW'((ms % MsPerMinute) / MsPerSecond);
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $realtime, what);
      mismatches++;
   endtask

   // Present one transaction and wait until it is taken; idle gap first
   task automatic send_request(input logic [DayW-1:0] day, input logic [MsW-1:0] ms,
                               input civil_date_type want);
      int unsigned gap;
      gap = 0;
      while ($urandom_range(99) < sender_idle_pct && gap < 40) gap++;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start           <= 1'b1;
      req_day_count   <= day;
      req_msec_of_day <= ms;
      do @(posedge clock); while (busy !== 1'b0);
      pending_dates.push_back(want);
      dates_sent++;
   endtask

   // Hold the sender off until every outstanding result has arrived
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (pending_dates.size() != 0);
   endtask

   function automatic logic [DayW-1:0] pick_day_count();
      int unsigned sel, yr;
      sel = $urandom_range(99);
      if (sel < 50) return DayW'($urandom_range(DayLast, DayFirst));
      if (sel < 70) begin
         // last or first days of a year
         yr = $urandom_range(9999, 1);
         return DayW'(days_through_year(yr) + $urandom_range(2) - 1);
      end
      if (sel < 82) begin
         // around the end of February
         yr = $urandom_range(9999, 1);
         return DayW'(days_through_year(yr - 1) + $urandom_range(61, 58));
      end
      if (sel < 90) return DayW'($urandom_range(1000, 0));
      if (sel < 95) return DayW'($urandom);
      return DayW'($urandom_range({DayW{1'b1}}, DayLast + 1));
   endfunction

   function automatic logic [MsW-1:0] pick_msec();
      int unsigned sel;
      sel = $urandom_range(99);
      if (sel < 65) return MsW'($urandom_range(MsLast, 0));
      if (sel < 80)
         // whole or nearly whole seconds at random hour, minute, second
         return MsW'($urandom_range(HoursPerDay - 1) * MsPerHour
                     + $urandom_range(MinutesPerHour - 1) * MsPerMinute
                     + $urandom_range(SecondsPerMinute - 1) * MsPerSecond
                     + ($urandom_range(1) ? 999 : 0));
      if (sel < 90) return MsW'($urandom);
      return MsW'($urandom_range({MsW{1'b1}}, MsLast + 1));
   endfunction

   // Result checker: every strobe must match the oldest expectation
   always @(posedge clock) begin
      civil_date_type want;
      cycle_count <= cycle_count + 1;
      if (cycle_count > LimitCycles) begin
         $display("timed out after %0d cycles, %0d results outstanding",
                  cycle_count, pending_dates.size());
         $display("[FAIL] regression broken");
         $finish;
      end else if (!reset && rsp_valid === 1'b1) begin
         if (pending_dates.size() == 0) begin
            report_mismatch("result with no transaction outstanding");
         end else begin
            want = pending_dates.pop_front();
            dates_checked++;
            if (rsp_year_from_1900 !== want.year)
               report_mismatch($sformatf("year got %0d want %0d",
                                         rsp_year_from_1900, want.year));
            if (rsp_month_index !== want.month)
               report_mismatch($sformatf("month got %0d want %0d",
                                         rsp_month_index, want.month));
            if (rsp_day_of_month !== want.mday)
               report_mismatch($sformatf("day of month got %0d want %0d",
                                         rsp_day_of_month, want.mday));
            if (rsp_day_of_year !== want.yday)
               report_mismatch($sformatf("day of year got %0d want %0d",
                                         rsp_day_of_year, want.yday));
            if (rsp_weekday !== want.wday)
               report_mismatch($sformatf("weekday got %0d want %0d",
                                         rsp_weekday, want.wday));
            if (rsp_hour !== want.hour)
               report_mismatch($sformatf("hour got %0d want %0d", rsp_hour, want.hour));
            if (rsp_minute !== want.minute)
               report_mismatch($sformatf("minute got %0d want %0d",
                                         rsp_minute, want.minute));
            if (rsp_second !== want.second)
               report_mismatch($sformatf("second got %0d want %0d",
                                         rsp_second, want.second));
         end
      end
   end

   // Stimulus
   initial begin
      directed_row_type directed [] = '{
         // day 1 and a zero day count both give 1 Jan of year 1
         '{22'd1,          27'd0,          1'b1, FirstDayMidnight},
         '{22'd0,          27'd0,          1'b1, FirstDayMidnight},
         // last day, and saturation of both fields
         '{DayLast,        MsLast,         1'b1, LastDayLastSecond},
         '{22'h3FFFFF,     27'h7FFFFFF,    1'b1, LastDayLastSecond},
         '{DayLast + 22'd1, MsLast + 27'd1, 1'b1, LastDayLastSecond},
         '{22'd0,          MsLast,         1'b0, '0},
         // year 1: end of February, start of March, turn of year
         '{22'd59,         27'd3599999,    1'b0, '0},
         '{22'd60,         27'd3600000,    1'b0, '0},
         '{22'd365,        27'd43200000,   1'b0, '0},
         '{22'd366,        27'd59999,      1'b0, '0},
         // year 4 leap day, 1 March and 31 December
         '{22'd1155,       27'd60000,      1'b0, '0},
         '{22'd1156,       27'd999,        1'b0, '0},
         '{22'd1461,       27'd1000,       1'b0, '0},
         // century year 100 is not leap
         '{22'd36219,      27'd123456,     1'b0, '0},
         '{22'd36524,      27'd86399000,   1'b0, '0},
         // year 400 is leap; the 400-year cycle boundary
         '{22'd145791,     27'd7654321,    1'b0, '0},
         '{22'd146097,     27'd50000000,   1'b0, '0},
         '{22'd146098,     27'd1,          1'b0, '0},
         // 1900 (no leap day) and 2000 (leap day)
         '{22'd693655,     27'd45296789,   1'b0, '0},
         '{22'd730179,     27'd82800000,   1'b0, '0},
         '{22'd730485,     27'd86340000,   1'b0, '0},
         '{DayLast - 22'd1, 27'd86399998,  1'b0, '0},
         // top bits of each field alone
         '{22'h200000,     27'h4000000,    1'b0, '0}
      };
      int unsigned idle_plan [3] = '{0, 48, 26};
      logic [DayW-1:0] day;
      logic [MsW-1:0]  ms;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed rows, back to back
      foreach (directed[i])
         send_request(directed[i].day, directed[i].ms,
                      directed[i].known ? directed[i].want
                                        : civil_date_of(directed[i].day, directed[i].ms));
      drain_results();

      // random transactions in three idling phases, drained between them
      foreach (idle_plan[p]) begin
         sender_idle_pct = idle_plan[p];
         for (int n = 0; n < RandomItems / 3; n++) begin
            day = pick_day_count();
            ms  = pick_msec();
            send_request(day, ms, civil_date_of(day, ms));
         end
         drain_results();
      end

      // tail: catch any stray strobe after the last expected result
      repeat (Latency + 5) @(posedge clock);
      $display("%0d transactions (%0d directed) over three idling phases, %0d results checked",
               dates_sent, directed.size(), dates_checked);
      $display("dates spanned years 1 to 9999 with leap days, century rules and saturation");
      if (mismatches == 0 && pending_dates.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("%0d mismatches, %0d results missing", mismatches, pending_dates.size());
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/dcdate_pkg.sv
hw/rtl/dcdate_tod_split.sv
hw/rtl/day_count_to_calendar_date_unit.sv
tb/tb_day_count_to_calendar_date_unit.sv
